### src/esc_pkg.sv
// ---------------------------------------------------------------------------
// esc_pkg
// shared types and constants for the epoch seconds to calendar converter
// ---------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

   // input and register widths
   localparam int EPOCH_W  = 32;
   localparam int OFFSET_W = 17;

   // zone offset register, reset to +8 hours
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd28800;

   // apb map: one word-wide register, word index taken from paddr[2]
   localparam int   CSR_ADDR_W   = 3;
   localparam int   CSR_DATA_W   = 32;
   localparam logic ZONE_REG_IDX = 1'b0;

   // intermediate widths
   localparam int DAYS_W = 16;   // whole days since 1970, below 49712
   localparam int REM_W  = 17;   // seconds within the day, below 86400

   // result widths
   localparam int RSP_DATA_W = 48;

   // day split between the two halves of the pipe
   typedef struct packed {
      logic [DAYS_W-1:0] days;
      logic [REM_W-1:0]  rem;
      logic              clamped;
   } day_split_type;

   // final calendar fields
   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
      logic        clamped;
   } calendar_type;

endpackage

`default_nettype wire

### src/esc_csr.sv
// ---------------------------------------------------------------------------
// esc_csr
// apb register file holding the signed time zone offset
// ---------------------------------------------------------------------------
`default_nettype none

module esc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [esc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [esc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [esc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready,
   output logic      [esc_pkg::OFFSET_W-1:0]     zone_offset
);

   logic [esc_pkg::OFFSET_W-1:0] offset_ff;
   logic [esc_pkg::OFFSET_W-1:0] offset_in;
   logic                         hit;

   // word decode
   assign hit = (paddr[2] == esc_pkg::ZONE_REG_IDX);

   // write on the access phase
   always_comb begin
      offset_in = offset_ff;
      if (psel && penable && pwrite && hit) begin
         offset_in = pwdata[esc_pkg::OFFSET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= esc_pkg::OFFSET_RESET;
      end else begin
         offset_ff <= offset_in;
      end
   end

   // read back sign extended
   always_comb begin
      prdata = '0;
      if (hit) begin
         prdata = {{(esc_pkg::CSR_DATA_W-esc_pkg::OFFSET_W){offset_ff[esc_pkg::OFFSET_W-1]}},
                   offset_ff};
      end
   end

   assign pready      = 1'b1;
   assign zone_offset = offset_ff;

endmodule

`default_nettype wire

### src/esc_days.sv
// ---------------------------------------------------------------------------
// esc_days
// three stage front end: zone offset and clamp, then split into days and
// seconds of day through a reciprocal multiply by 1/86400
// ---------------------------------------------------------------------------
`default_nettype none

module esc_days (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [esc_pkg::OFFSET_W-1:0]    zone_offset,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [esc_pkg::EPOCH_W-1:0]     epoch,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output esc_pkg::day_split_type               out_data
);

   // 86400 = 128 * 675; ceil(2^36 / 675) is exact for quotients of 26-bit values
   localparam logic [26:0] RECIP_DAY = 27'd101806633;
   localparam logic [9:0]  DAY_DIV   = 10'd675;

   // stage enables, a stage moves when empty or when the next one moves
   logic en1, en2, en3;
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign v1_in = en1 ? in_valid : v1_ff;
   assign v2_in = en2 ? v1_ff    : v2_ff;
   assign v3_in = en3 ? v2_ff    : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage 1: add the offset, clamp negative time to zero
   logic [33:0] sum;
   logic [32:0] t1_ff, t1_in;
   logic        clamped1_ff, clamped1_in;

   always_comb begin
      sum = {2'b00, epoch}
          + {{(34-esc_pkg::OFFSET_W){zone_offset[esc_pkg::OFFSET_W-1]}}, zone_offset};
      clamped1_in = sum[33];
      t1_in       = sum[33] ? 33'd0 : sum[32:0];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         t1_ff       <= t1_in;
         clamped1_ff <= clamped1_in;
      end
   end

   // stage 2: reciprocal product for the day count
   logic [25:0] x1;
   logic [52:0] pd2_in;
   logic [15:0] q2_ff;
   logic [25:0] x2_ff;
   logic [6:0]  lo2_ff;
   logic        clamped2_ff;

   assign x1     = t1_ff[32:7];
   assign pd2_in = {27'd0, x1} * {26'd0, RECIP_DAY};

   always_ff @(posedge clock) begin
      if (en2) begin
         q2_ff       <= pd2_in[51:36];
         x2_ff       <= x1;
         lo2_ff      <= t1_ff[6:0];
         clamped2_ff <= clamped1_ff;
      end
   end

   // stage 3: remainder gives the seconds within the day
   logic [25:0] back;
   logic [25:0] r3;
   esc_pkg::day_split_type s3_ff, s3_in;

   always_comb begin
      back           = {10'd0, q2_ff} * {16'd0, DAY_DIV};
      r3             = x2_ff - back;
      s3_in.days     = q2_ff;
      s3_in.rem      = {r3[9:0], lo2_ff};
      s3_in.clamped  = clamped2_ff;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

endmodule

`default_nettype wire

### src/esc_date.sv
// ---------------------------------------------------------------------------
// esc_date
// four stage back end: year, day of year, month and day from a table of
// cumulative month lengths, plus hour, minute, second and day of week
// ---------------------------------------------------------------------------
`default_nettype none

module esc_date (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire esc_pkg::day_split_type  in_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output esc_pkg::calendar_type        out_data
);

   // exact reciprocals for the ranges seen here
   localparam logic [15:0] RECIP_YEAR = 16'd45965;   // ceil(2^24 / 365)
   localparam logic [12:0] RECIP_HOUR = 13'd4661;    // ceil(2^20 / 225)
   localparam logic [10:0] RECIP_MIN  = 11'd1093;    // ceil(2^14 / 15)
   localparam logic [16:0] RECIP_WEEK = 17'd74899;   // ceil(2^19 / 7)
   localparam logic [7:0]  CENTURY_IDX = 8'd130;     // year 2100, not a leap year
   localparam logic [11:0] BASE_YEAR  = 12'd1970;

   typedef logic [8:0] mtab_type [0:12];
   localparam mtab_type DAYS_BEFORE_COMMON =
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
   localparam mtab_type DAYS_BEFORE_LEAP =
      '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

   // leap test on a year index from 1970, valid through 2106
   function automatic logic is_leap_idx(input logic [7:0] idx);
      return (idx[1:0] == 2'd2) && (idx != CENTURY_IDX);
   endfunction

   // stage control
   logic en4, en5, en6, en7;
   logic v4_ff, v5_ff, v6_ff, v7_ff;

   assign en7      = !v7_ff || out_ready;
   assign en6      = !v6_ff || en7;
   assign en5      = !v5_ff || en6;
   assign en4      = !v4_ff || en5;
   assign in_ready = en4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (en4) v4_ff <= in_valid;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
         if (en7) v7_ff <= v6_ff;
      end
   end

   // stage 4: reciprocal products for year, hour and week
   logic [31:0] py;
   logic [25:0] ph;
   logic [16:0] w;
   logic [33:0] pw;
   logic [7:0]  yidx4_ff;
   logic [4:0]  hour4_ff;
   logic [13:0] wq4_ff;
   logic [16:0] w4_ff;
   logic [15:0] days4_ff;
   logic [16:0] rem4_ff;
   logic        clamped4_ff;

   always_comb begin
      w  = {1'b0, in_data.days} + 17'd4;
      py = {16'd0, in_data.days} * {16'd0, RECIP_YEAR};
      ph = {13'd0, in_data.rem[16:4]} * {13'd0, RECIP_HOUR};
      pw = {17'd0, w} * {17'd0, RECIP_WEEK};
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         yidx4_ff    <= py[31:24];
         hour4_ff    <= ph[24:20];
         wq4_ff      <= pw[32:19];
         w4_ff       <= w;
         days4_ff    <= in_data.days;
         rem4_ff     <= in_data.rem;
         clamped4_ff <= in_data.clamped;
      end
   end

   // stage 5: start day of the estimated year, seconds left in the hour, weekday
   logic [7:0]  yp1;
   logic [16:0] start_full;
   logic [16:0] r2_full;
   logic [16:0] wd_full;
   logic [7:0]  yidx5_ff;
   logic [15:0] start5_ff;
   logic [15:0] days5_ff;
   logic [11:0] r2_5_ff;
   logic [4:0]  hour5_ff;
   logic [2:0]  wday5_ff;
   logic        clamped5_ff;

   always_comb begin
      yp1        = yidx4_ff + 8'd1;
      start_full = {9'd0, yidx4_ff} * 17'd365 + {11'd0, yp1[7:2]}
                 - {16'd0, (yidx4_ff > CENTURY_IDX)};
      r2_full    = rem4_ff - {12'd0, hour4_ff} * 17'd3600;
      wd_full    = w4_ff - {3'd0, wq4_ff} * 17'd7;
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         yidx5_ff    <= yidx4_ff;
         start5_ff   <= start_full[15:0];
         days5_ff    <= days4_ff;
         r2_5_ff     <= r2_full[11:0];
         hour5_ff    <= hour4_ff;
         wday5_ff    <= wd_full[2:0];
         clamped5_ff <= clamped4_ff;
      end
   end

   // stage 6: step the year back by one when the estimate overshoots
   logic        over;
   logic [7:0]  yprev;
   logic [15:0] start_prev;
   logic [7:0]  yidx_sel;
   logic [15:0] start_sel;
   logic [15:0] dy_full;
   logic [20:0] pm;
   logic [7:0]  yidx6_ff;
   logic [8:0]  dy6_ff;
   logic        leap6_ff;
   logic [5:0]  minute6_ff;
   logic [11:0] r2_6_ff;
   logic [4:0]  hour6_ff;
   logic [2:0]  wday6_ff;
   logic        clamped6_ff;

   always_comb begin
      over       = days5_ff < start5_ff;
      yprev      = yidx5_ff - 8'd1;
      start_prev = start5_ff - 16'd365 - {15'd0, is_leap_idx(yprev)};
      yidx_sel   = over ? yprev : yidx5_ff;
      start_sel  = over ? start_prev : start5_ff;
      dy_full    = days5_ff - start_sel;
      pm         = {11'd0, r2_5_ff[11:2]} * {10'd0, RECIP_MIN};
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         yidx6_ff    <= yidx_sel;
         dy6_ff      <= dy_full[8:0];
         leap6_ff    <= is_leap_idx(yidx_sel);
         minute6_ff  <= pm[19:14];
         r2_6_ff     <= r2_5_ff;
         hour6_ff    <= hour5_ff;
         wday6_ff    <= wday5_ff;
         clamped6_ff <= clamped5_ff;
      end
   end

   // stage 7: month search over the cumulative table, result register
   mtab_type              tab;
   logic [3:0]            month;
   logic [8:0]            base;
   logic [8:0]            day_full;
   logic [11:0]           sec_full;
   esc_pkg::calendar_type cal_in, cal_ff;

   always_comb begin
      for (int i = 0; i <= 12; i++) begin
         tab[i] = leap6_ff ? DAYS_BEFORE_LEAP[i] : DAYS_BEFORE_COMMON[i];
      end
      month = 4'd1;
      base  = tab[0];
      // scan downward so the first month whose end lies past the day wins
      for (int m = 12; m >= 1; m--) begin
         if (tab[m] > dy6_ff) begin
            month = 4'(m);
            base  = tab[m-1];
         end
      end
      day_full = dy6_ff - base + 9'd1;
      sec_full = r2_6_ff - {6'd0, minute6_ff} * 12'd60;

      cal_in.year    = BASE_YEAR + {4'd0, yidx6_ff};
      cal_in.month   = month;
      cal_in.day     = day_full[4:0];
      cal_in.hour    = hour6_ff;
      cal_in.minute  = minute6_ff;
      cal_in.second  = sec_full[5:0];
      cal_in.weekday = wday6_ff;
      cal_in.clamped = clamped6_ff;
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         cal_ff <= cal_in;
      end
   end

   assign out_valid = v7_ff;
   assign out_data  = cal_ff;

endmodule

`default_nettype wire

### src/epoch_seconds_to_calendar.sv
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar
// converts unix epoch seconds plus a zone offset to gregorian date and time
// ---------------------------------------------------------------------------
//
//   channel  direction  width     contents
//   req      in         32        epoch seconds
//   rsp      out        48 + 1    year .. weekday in tdata, clamp flag in tuser
//   csr      apb        3 / 32    zone offset at byte address 0
//
// a timestamp can enter each cycle unless rsp stalls; its result passes one
// pipeline register per stage (three in the day split, four in the date split).
// with rsp ready, the seven stage pipe sustains one transaction per cycle.
// reset clears the stage valid bits and loads the offset with +8 hours.
// a stalled rsp holds only the stages that are full; empty stages still fill.
`default_nettype none

module epoch_seconds_to_calendar (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [esc_pkg::EPOCH_W-1:0]      req_tdata,   // [31:0] epoch_seconds
   // result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [11:0] year, [15:12] month, [20:16] day, [25:21] hour, [31:26] minute,
   // [37:32] second, [40:38] weekday, [47:41] zero
   output logic      [esc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                  rsp_tuser,   // [0] clamped
   // configuration
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [esc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [esc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [esc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   logic [esc_pkg::OFFSET_W-1:0] zone_offset;
   logic                         mid_valid;
   logic                         mid_ready;
   esc_pkg::day_split_type       mid_data;
   esc_pkg::calendar_type        cal;

   // register file
   esc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .zone_offset (zone_offset)
   );

   // offset, clamp and day split
   esc_days u_days (
      .clock       (clock),
      .reset       (reset),
      .zone_offset (zone_offset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .epoch       (req_tdata),
      .out_valid   (mid_valid),
      .out_ready   (mid_ready),
      .out_data    (mid_data)
   );

   // calendar fields
   esc_date u_date (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (cal)
   );

   // pack the result
   assign rsp_tdata = {7'd0, cal.weekday, cal.second, cal.minute, cal.hour,
                       cal.day, cal.month, cal.year};
   assign rsp_tuser = cal.clamped;

   // a clamped result is always the epoch start, a thursday
   a_clamp_epoch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         cal.year == 12'd1970 && cal.month == 4'd1 && cal.day == 5'd1 &&
         cal.hour == 5'd0 && cal.minute == 6'd0 && cal.second == 6'd0 &&
         cal.weekday == 3'd4)
      else $error("clamped result is not 1970-01-01 00:00:00");

   // month and day stay in their calendar range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cal.month >= 4'd1 && cal.month <= 4'd12 &&
                     cal.day >= 5'd1 && cal.day <= 5'd31)
      else $error("month or day out of range");

   // time of day and weekday come out fully reduced
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cal.hour <= 5'd23 && cal.minute <= 6'd59 &&
                     cal.second <= 6'd59 && cal.weekday <= 3'd6)
      else $error("time field or weekday out of range");

   // input backpressure only comes from a full pipe behind a stalled output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
